// ===== design/gtpc_pkg.sv =====
package gtpc_pkg;

  // Default width of a gray sample and of the window registers (signed Q16.8).
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  // Ramp geometry: position runs over 0..RAMP_SPAN, the halves meet at RAMP_HALF.
  localparam int unsigned RAMP_SPAN = 510;
  localparam int unsigned RAMP_HALF = 255;
  localparam int unsigned Q_BITS    = 9;
  localparam int unsigned COLOR_BITS = 8;

  // Reset value of the upper window bound (255.0 in Q16.8).
  localparam logic [63:0] MAX_GRAY_RESET = 64'd65280;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_GRAY = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_GRAY = 2'd1;

  // Depth of the queue between classification and division.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Window class of one word, decided before the division.
  typedef enum logic [1:0] {
    CLS_NORMAL = 2'd0,
    CLS_EMPTY  = 2'd1,
    CLS_INVERT = 2'd2
  } cls_e;

endpackage

// ===== design/gtpc_in_if.sv =====
interface gtpc_in_if import gtpc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] gray_sample;

  modport source (output valid, output gray_sample, input ready);
  modport sink   (input valid, input gray_sample, output ready);
endinterface

// ===== design/gtpc_out_if.sv =====
interface gtpc_out_if import gtpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COLOR_BITS-1:0] red_out;
  logic [COLOR_BITS-1:0] green_out;
  logic [COLOR_BITS-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

// ===== design/gtpc_front.sv =====
module gtpc_front import gtpc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]  cfg_wdata_i,
  gtpc_in_if.sink                 pix_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output logic [SAMPLE_BITS-1:0]  num_o,
  output logic [SAMPLE_BITS-1:0]  den_o,
  output cls_e                    cls_o
);

  localparam logic [SAMPLE_BITS-1:0] MAX_RST = SAMPLE_BITS'(MAX_GRAY_RESET);

  logic signed [SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d;
  logic signed [SAMPLE_BITS-1:0] s_clamp;
  logic signed [SAMPLE_BITS:0]   num_wide, den_wide;

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_GRAY: min_d = cfg_wdata_i;
        REG_MAX_GRAY: max_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= MAX_RST;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // The queue takes a word whenever it has room.
  assign pix_i.ready = !q_full_i;
  assign push_o      = pix_i.valid && !q_full_i;

  always_comb begin
    if (pix_i.gray_sample < min_q) begin
      s_clamp = min_q;
    end else if (pix_i.gray_sample > max_q) begin
      s_clamp = max_q;
    end else begin
      s_clamp = pix_i.gray_sample;
    end
    num_wide = {s_clamp[SAMPLE_BITS-1], s_clamp} - {min_q[SAMPLE_BITS-1], min_q};
    den_wide = {max_q[SAMPLE_BITS-1], max_q} - {min_q[SAMPLE_BITS-1], min_q};

    if (max_q == min_q) begin
      cls_o = CLS_EMPTY;
    end else if (max_q < min_q) begin
      cls_o = CLS_INVERT;
    end else begin
      cls_o = CLS_NORMAL;
    end
  end

  // In a normal window both differences are non-negative and fit unsigned.
  assign num_o = num_wide[SAMPLE_BITS-1:0];
  assign den_o = den_wide[SAMPLE_BITS-1:0];

endmodule

// ===== design/gtpc_fifo.sv =====
module gtpc_fifo import gtpc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [SAMPLE_BITS-1:0] num_i,
  input  logic [SAMPLE_BITS-1:0] den_i,
  input  cls_e                   cls_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output logic [SAMPLE_BITS-1:0] num_o,
  output logic [SAMPLE_BITS-1:0] den_o,
  output cls_e                   cls_o
);

  localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(QUEUE_DEPTH);

  logic [SAMPLE_BITS-1:0] num_mem [QUEUE_DEPTH];
  logic [SAMPLE_BITS-1:0] den_mem [QUEUE_DEPTH];
  cls_e                   cls_mem [QUEUE_DEPTH];

  logic [PTR_BITS-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                do_pop;

  assign full_o  = (cnt_q == FULL);
  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;

  assign num_o = num_mem[rd_q];
  assign den_o = den_mem[rd_q];
  assign cls_o = cls_mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LAST) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LAST) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      num_mem[wr_q] <= num_i;
      den_mem[wr_q] <= den_i;
      cls_mem[wr_q] <= cls_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue written while full");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL)
    else $error("queue fill count out of range");

endmodule

// ===== design/gtpc_back.sv =====
module gtpc_back import gtpc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  logic [SAMPLE_BITS-1:0] num_i,
  input  logic [SAMPLE_BITS-1:0] den_i,
  input  cls_e                   cls_i,
  output logic                   pop_o,
  gtpc_out_if.source             rgb_o
);

  localparam int unsigned RW     = SAMPLE_BITS + Q_BITS;
  localparam int unsigned NSTAGE = Q_BITS;

  // Stage 0 holds the scaled numerator; stage k has resolved quotient bit Q_BITS-k.
  logic [RW-1:0]          rem_q [NSTAGE+1];
  logic [SAMPLE_BITS-1:0] den_q [NSTAGE+1];
  logic [Q_BITS-1:0]      quo_q [NSTAGE+1];
  cls_e                   cls_q [NSTAGE+1];
  logic [NSTAGE:0]        vld_q;

  logic [RW-1:0]          rem_d [NSTAGE+1];
  logic [Q_BITS-1:0]      quo_d [NSTAGE+1];

  logic                  out_vld_q;
  logic [COLOR_BITS-1:0] red_q, green_q, blue_q;
  logic [COLOR_BITS-1:0] red_d, green_d, blue_d;
  logic [Q_BITS-1:0]     pos;
  logic                  adv;

  // The whole pipe moves when the output register is free or being emptied.
  assign adv   = !out_vld_q || rgb_o.ready;
  assign pop_o = adv;

  assign rem_d[0] = RW'(num_i) * RW'(RAMP_SPAN);
  assign quo_d[0] = '0;

  for (genvar k = 1; k <= NSTAGE; k++) begin : g_div
    localparam int unsigned SH = NSTAGE - k;
    logic [RW:0] trial;
    assign trial = {1'b0, rem_q[k-1]} - ({1'b0, RW'(den_q[k-1])} << SH);
    always_comb begin
      rem_d[k] = rem_q[k-1];
      quo_d[k] = quo_q[k-1];
      if (!trial[RW]) begin
        rem_d[k]     = trial[RW-1:0];
        quo_d[k][SH] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NSTAGE-1:0], q_valid_i};
      out_vld_q <= vld_q[NSTAGE];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0] <= rem_d[0];
      den_q[0] <= den_i;
      quo_q[0] <= quo_d[0];
      cls_q[0] <= cls_i;
      for (int k = 1; k <= NSTAGE; k++) begin
        rem_q[k] <= rem_d[k];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= quo_d[k];
        cls_q[k] <= cls_q[k-1];
      end
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  always_comb begin
    case (cls_q[NSTAGE])
      CLS_NORMAL: pos = quo_q[NSTAGE];
      CLS_EMPTY:  pos = '0;
      CLS_INVERT: pos = Q_BITS'(RAMP_SPAN);
      default:    pos = '0;
    endcase
    if (pos < Q_BITS'(RAMP_HALF)) begin
      red_d   = '0;
      green_d = pos[COLOR_BITS-1:0];
      blue_d  = COLOR_BITS'(Q_BITS'(RAMP_HALF) - pos);
    end else begin
      red_d   = COLOR_BITS'(pos - Q_BITS'(RAMP_HALF));
      green_d = COLOR_BITS'(Q_BITS'(RAMP_SPAN) - pos);
      blue_d  = '0;
    end
  end

  assign rgb_o.valid     = out_vld_q;
  assign rgb_o.red_out   = red_q;
  assign rgb_o.green_out = green_q;
  assign rgb_o.blue_out  = blue_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NSTAGE] && cls_q[NSTAGE] == CLS_NORMAL) |-> quo_q[NSTAGE] <= Q_BITS'(RAMP_SPAN))
    else $error("ramp position beyond span");

  a_ramp_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (({1'b0, red_q} + {1'b0, green_q} + {1'b0, blue_q}) ==
                   (COLOR_BITS + 1)'(RAMP_HALF)) && (red_q == '0 || blue_q == '0))
    else $error("color word off the ramp");

endmodule

// ===== design/gray_to_pseudocolor_ramp.sv =====
// Gray to pseudocolor ramp: maps a signed Q16.8 gray sample onto a
// blue -> green -> red color ramp over a programmable window.
// Input channel pix_i carries one gray_sample per word; output channel rgb_o
// carries red_out, green_out and blue_out per word, one output word for each
// input word, in order. Both use valid/ready; a word moves when both are high.
// The window registers (index 0 min_gray, index 1 max_gray) are written via
// cfg_we_i/cfg_idx_i/cfg_wdata_i and must only change while the block is idle.
// From input acceptance to output valid, a word passes the input queue, the
// register that captures the scaled numerator, the pipelined divider that
// resolves one quotient bit per stage, and the color output register.
// Throughput is one word per cycle while rgb_o does not stall; the divider
// is fully pipelined.
// When rgb_o stalls, the whole back pipeline holds, and the two-entry queue
// keeps accepting input until it fills, after which pix_i.ready drops.
// Reset clears the queue and pipeline valid bits and loads min_gray = 0 and
// max_gray = 255.0.
module gray_to_pseudocolor_ramp import gtpc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]  cfg_wdata_i,
  gtpc_in_if.sink                 pix_i,
  gtpc_out_if.source              rgb_o
);

  logic                   push, q_full, pop, q_valid;
  logic [SAMPLE_BITS-1:0] f_num, f_den, b_num, b_den;
  cls_e                   f_cls, b_cls;

  gtpc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .num_o       (f_num),
    .den_o       (f_den),
    .cls_o       (f_cls)
  );

  gtpc_fifo #(.SAMPLE_BITS(SAMPLE_BITS)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .num_i   (f_num),
    .den_i   (f_den),
    .cls_i   (f_cls),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .num_o   (b_num),
    .den_o   (b_den),
    .cls_o   (b_cls)
  );

  gtpc_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .num_i     (b_num),
    .den_i     (b_den),
    .cls_i     (b_cls),
    .pop_o     (pop),
    .rgb_o     (rgb_o)
  );

endmodule

// ===== dv/ramp_checker.sv =====
module ramp_checker import gtpc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]  cfg_wdata_i,
  gtpc_in_if                      pix_i,
  gtpc_out_if                     rgb_i,
  output int                      errors_o,
  output int                      pending_o
);

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } color_t;

  logic signed [SAMPLE_BITS-1:0] win_lo;
  logic signed [SAMPLE_BITS-1:0] win_hi;
  color_t                        colors_due[$];
  color_t                        due;
  color_t                        seen;
  int                            errs;

  function automatic color_t ramp_color(input logic signed [SAMPLE_BITS-1:0] gray,
                                        input logic signed [SAMPLE_BITS-1:0] lo,
                                        input logic signed [SAMPLE_BITS-1:0] hi);
    longint g;
    longint l;
    longint h;
    longint pos;
    color_t c;
    g = longint'(gray);
    l = longint'(lo);
    h = longint'(hi);
    if (h == l) begin
      pos = 0;
    end else if (h < l) begin
      pos = longint'(RAMP_SPAN);
    end else begin
      if (g < l) g = l;
      if (g > h) g = h;
      pos = ((g - l) * longint'(RAMP_SPAN)) / (h - l);
    end
    if (pos < longint'(RAMP_HALF)) begin
      c.red   = '0;
      c.green = COLOR_BITS'(pos);
      c.blue  = COLOR_BITS'(longint'(RAMP_HALF) - pos);
    end else begin
      c.red   = COLOR_BITS'(pos - longint'(RAMP_HALF));
      c.green = COLOR_BITS'(longint'(RAMP_SPAN) - pos);
      c.blue  = '0;
    end
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo = '0;
      win_hi = SAMPLE_BITS'(MAX_GRAY_RESET);
      colors_due.delete();
      errs = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_GRAY: win_lo = cfg_wdata_i;
          REG_MAX_GRAY: win_hi = cfg_wdata_i;
          default: ;
        endcase
      end
      // A word leaving now belongs to an earlier input, so retire before pushing.
      if (rgb_i.valid && rgb_i.ready) begin
        seen.red   = rgb_i.red_out;
        seen.green = rgb_i.green_out;
        seen.blue  = rgb_i.blue_out;
        if (colors_due.size() == 0) begin
          if (errs < 10) begin
            $display("unexpected word: r=%0d g=%0d b=%0d", seen.red, seen.green, seen.blue);
          end
          errs++;
        end else begin
          due = colors_due.pop_front();
          if (seen.red !== due.red || seen.green !== due.green || seen.blue !== due.blue) begin
            if (errs < 10) begin
              $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       due.red, due.green, due.blue, seen.red, seen.green, seen.blue);
            end
            errs++;
          end
        end
      end
      if (pix_i.valid && pix_i.ready) begin
        colors_due.push_back(ramp_color(pix_i.gray_sample, win_lo, win_hi));
      end
      errors_o  <= errs;
      pending_o <= colors_due.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import gtpc_pkg::*;

  localparam int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam longint GRAY_MIN = -(longint'(1) <<< (SAMPLE_BITS - 1));
  localparam longint GRAY_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam int RANDOM_WORDS = 1950;
  localparam int DRAIN_CYCLES = 32;
  // Indexes past the window registers; writes to them must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [SAMPLE_BITS-1:0]  cfg_wdata;
  int                      errors;
  int                      pending;
  int                      tx_left;
  bit                      tx_calm;

  gtpc_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) pix_if ();
  gtpc_out_if rgb_if ();

  gray_to_pseudocolor_ramp #(.SAMPLE_BITS(SAMPLE_BITS)) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix_if),
    .rgb_o       (rgb_if)
  );

  ramp_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix_if),
    .rgb_i       (rgb_if),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint random_gray();
    logic signed [SAMPLE_BITS-1:0] v;
    v = SAMPLE_BITS'($urandom);
    return longint'(v);
  endfunction

  function automatic longint pick_sample(input longint lo, input longint hi);
    longint span;
    longint s;
    span = hi - lo;
    case ($urandom_range(0, 9))
      0: s = random_gray();
      1: s = lo;
      2: s = hi;
      3: s = lo - longint'($urandom_range(1, 300));
      4: s = hi + longint'($urandom_range(1, 300));
      default: begin
        if (span <= 0) s = random_gray();
        else s = lo + longint'($urandom) % (span + 1);
      end
    endcase
    return s;
  endfunction

  task automatic pick_window(output longint lo, output longint hi);
    case ($urandom_range(0, 7))
      0: begin
        lo = GRAY_MIN;
        hi = GRAY_MAX;
      end
      1: begin
        lo = random_gray();
        hi = random_gray();
      end
      2: begin
        lo = random_gray();
        hi = lo;
      end
      3: begin
        lo = random_gray();
        hi = lo + longint'($urandom_range(1, 1100));
      end
      4: begin
        lo = random_gray();
        hi = lo + longint'($urandom_range(1, 1 << 20));
      end
      5: begin
        hi = random_gray();
        lo = hi + longint'($urandom_range(1, 1 << 20));
      end
      6: begin
        lo = GRAY_MIN;
        hi = random_gray();
      end
      default: begin
        lo = random_gray();
        hi = GRAY_MAX;
      end
    endcase
    if (lo > GRAY_MAX) lo = GRAY_MAX;
    if (hi > GRAY_MAX) hi = GRAY_MAX;
  endtask

  // Holds the sender until the checker has nothing outstanding.
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input longint value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= SAMPLE_BITS'(value);
    @(posedge clk);
  endtask

  task automatic set_window(input longint lo, input longint hi, input bit poke_spare);
    wait_idle();
    write_reg(REG_MIN_GRAY, lo);
    write_reg(REG_MAX_GRAY, hi);
    if (poke_spare) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, random_gray());
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_gray(input longint value);
    int gap;
    if (tx_left == 0) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      tx_left = $urandom_range(20, 200);
    end
    tx_left--;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.gray_sample <= SAMPLE_BITS'(value);
    do @(posedge clk); while (!pix_if.ready);
  endtask

  initial begin : color_sink
    int  stall;
    int  left;
    bit  calm;
    rgb_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        left = $urandom_range(20, 200);
      end
      left--;
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        rgb_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rgb_if.ready <= 1'b1;
      do @(posedge clk); while (!rgb_if.valid);
    end
  end

  initial begin : stimulus
    longint lo;
    longint hi;
    int     left;
    int     n;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= REG_MIN_GRAY;
    cfg_wdata          <= '0;
    pix_if.valid       <= 1'b0;
    pix_if.gray_sample <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Window left at its reset value, 0.0 to 255.0.
    send_gray(0);
    send_gray(32640);
    send_gray(65280);
    send_gray(65279);
    send_gray(GRAY_MIN);
    send_gray(GRAY_MAX);
    send_gray(255);
    send_gray(256);
    send_gray(1);

    // With a 510-wide window the ramp position equals the sample, so the
    // crossover between the two halves can be hit exactly.
    set_window(0, 510, 1'b0);
    send_gray(254);
    send_gray(255);
    send_gray(256);
    send_gray(509);

    set_window(GRAY_MIN, GRAY_MAX, 1'b0);
    send_gray(GRAY_MIN);
    send_gray(GRAY_MAX);
    send_gray(0);
    send_gray(-1);

    set_window(1000, 1000, 1'b0);
    send_gray(1000);
    send_gray(-5);

    // Inverted window, then a write to an unused index that must not disturb it.
    set_window(5000, -5000, 1'b1);
    send_gray(0);
    send_gray(GRAY_MAX);
    send_gray(GRAY_MIN);

    left = RANDOM_WORDS;
    while (left > 0) begin
      pick_window(lo, hi);
      set_window(lo, hi, $urandom_range(0, 5) == 0);
      n = $urandom_range(10, 150);
      if (n > left) n = left;
      repeat (n) send_gray(pick_sample(lo, hi));
      left -= n;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
